// ===== sv/vlpd_pkg.sv =====
// Shared widths and status codes for the varint length-prefixed string deframer.
// No dependencies.
package vlpd_pkg;

    localparam int unsigned LEN_W   = 64;  // length accumulator and payload counter
    localparam int unsigned SHIFT_W = 7;   // header shift, holds up to 70
    localparam int unsigned DIGIT_W = 7;   // value bits in one header byte
    localparam int unsigned BYTE_W  = 8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_MISMATCH  = 2'd2;
    localparam logic [1:0] ST_NO_TERM   = 2'd3;

endpackage

// ===== sv/varint_length_prefixed_string_deframer.sv =====
// Deframer for strings prefixed by a bijective base-128 varint length.
// Depends on vlpd_pkg for widths and status codes.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one byte of the encoded buffer per
//   beat, with last_byte set on the buffer's final byte. Output channel
//   (out_valid/out_ready) returns exactly one result beat per input beat:
//   payload_byte/payload_valid for bytes after the header terminator,
//   decoded_length as accumulated so far, and on the final byte done_res with
//   status (ok, length too large, length mismatch, missing terminator).
//   After a header overflow the remaining bytes are swallowed until the final
//   byte, which reports the error; the final byte always clears the state.
// Pipeline and throughput:
//   A beat is held in an input register, decoded by one 64-bit add with a
//   barrel-shifted digit, and lands in the output register. One beat per
//   cycle is sustained while out_ready stays high; the decode state updates
//   in the same cycle the result register loads.
// Reset clears the header state, counters and both pipeline valid flags.
// When the receiver stalls, the output register holds, the input register
// takes one more beat only if it is empty, then in_ready drops until out_ready returns.
module varint_length_prefixed_string_deframer
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [vlpd_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         last_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [vlpd_pkg::BYTE_W-1:0]  payload_byte,
    output logic                         payload_valid,
    output logic                         done_res,
    output logic [1:0]                   status,
    output logic [vlpd_pkg::LEN_W-1:0]   decoded_length
);

    localparam int unsigned WIDE_W = vlpd_pkg::LEN_W + vlpd_pkg::DIGIT_W;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SWALLOW = 2'd2
    } phase_t;

    // input stage
    logic                         in_vld_reg;
    logic [vlpd_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                         in_last_reg;

    // decode state
    phase_t                       phase_reg, phase_next;
    logic [vlpd_pkg::LEN_W-1:0]   accum_reg, accum_next;
    logic [vlpd_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [vlpd_pkg::LEN_W-1:0]   count_reg, count_next;
    logic [1:0]                   error_reg, error_next;

    // output stage
    logic                         out_vld_reg;
    logic [vlpd_pkg::BYTE_W-1:0]  pbyte_reg, pbyte_next;
    logic                         pvalid_reg, pvalid_next;
    logic                         done_reg;
    logic [1:0]                   status_reg, status_next;
    logic [vlpd_pkg::LEN_W-1:0]   dlen_reg;

    logic                         advance;
    logic                         fire;
    logic [vlpd_pkg::DIGIT_W-1:0] low;
    logic                         cont;
    logic [WIDE_W-1:0]            wide;
    logic                         ovf;
    logic [vlpd_pkg::SHIFT_W-1:0] shift_inc;
    logic [vlpd_pkg::LEN_W-1:0]   one_bit;
    logic [vlpd_pkg::LEN_W-1:0]   sum;
    logic [vlpd_pkg::LEN_W-1:0]   count_inc;

    assign advance  = !out_vld_reg || out_ready;
    assign fire     = in_vld_reg && advance;
    assign in_ready = !in_vld_reg || advance;

    always_comb
    begin
        low       = in_byte_reg[vlpd_pkg::DIGIT_W-1:0];
        cont      = in_byte_reg[vlpd_pkg::BYTE_W-1];
        wide      = {{vlpd_pkg::LEN_W{1'b0}}, low} << shift_reg;
        // shift at or past 64, or digit bits pushed beyond bit 63
        ovf       = shift_reg[vlpd_pkg::SHIFT_W-1] || (|wide[WIDE_W-1:vlpd_pkg::LEN_W]);
        shift_inc = shift_reg + vlpd_pkg::SHIFT_W'(vlpd_pkg::DIGIT_W);
        // implied one lands just above the digit, so it never overlaps it
        if (cont && !shift_inc[vlpd_pkg::SHIFT_W-1])
        begin
            one_bit = vlpd_pkg::LEN_W'(1) << shift_inc[vlpd_pkg::SHIFT_W-2:0];
        end
        else
        begin
            one_bit = '0;
        end
        sum       = accum_reg + (wide[vlpd_pkg::LEN_W-1:0] | one_bit);
        count_inc = count_reg + vlpd_pkg::LEN_W'(1);

        phase_next  = phase_reg;
        accum_next  = accum_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        error_next  = error_reg;
        pbyte_next  = '0;
        pvalid_next = 1'b0;
        status_next = vlpd_pkg::ST_OK;

        case (phase_reg)
            PH_PAYLOAD:
            begin
                pbyte_next  = in_byte_reg;
                pvalid_next = 1'b1;
                count_next  = count_inc;
                if (in_last_reg)
                begin
                    status_next = (count_inc == accum_reg) ? vlpd_pkg::ST_OK
                                                           : vlpd_pkg::ST_MISMATCH;
                end
            end
            PH_SWALLOW:
            begin
                if (in_last_reg)
                begin
                    status_next = error_reg;
                end
            end
            default:
            begin
                if (ovf)
                begin
                    error_next = vlpd_pkg::ST_TOO_LARGE;
                    phase_next = PH_SWALLOW;
                    if (in_last_reg)
                    begin
                        status_next = vlpd_pkg::ST_TOO_LARGE;
                    end
                end
                else
                begin
                    accum_next = sum;
                    if (!cont)
                    begin
                        phase_next = PH_PAYLOAD;
                        if (in_last_reg)
                        begin
                            status_next = (sum == '0) ? vlpd_pkg::ST_OK
                                                      : vlpd_pkg::ST_MISMATCH;
                        end
                    end
                    else
                    begin
                        shift_next = shift_inc;
                        if (shift_inc[vlpd_pkg::SHIFT_W-1])
                        begin
                            error_next = vlpd_pkg::ST_TOO_LARGE;
                            phase_next = PH_SWALLOW;
                            if (in_last_reg)
                            begin
                                status_next = vlpd_pkg::ST_TOO_LARGE;
                            end
                        end
                        else if (in_last_reg)
                        begin
                            status_next = vlpd_pkg::ST_NO_TERM;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_HEADER;
            accum_reg   <= '0;
            shift_reg   <= '0;
            count_reg   <= '0;
            error_reg   <= vlpd_pkg::ST_OK;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (fire)
            begin
                if (in_last_reg)
                begin
                    phase_reg <= PH_HEADER;
                    accum_reg <= '0;
                    shift_reg <= '0;
                    count_reg <= '0;
                    error_reg <= vlpd_pkg::ST_OK;
                end
                else
                begin
                    phase_reg <= phase_next;
                    accum_reg <= accum_next;
                    shift_reg <= shift_next;
                    count_reg <= count_next;
                    error_reg <= error_next;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (fire)
        begin
            pbyte_reg  <= pbyte_next;
            pvalid_reg <= pvalid_next;
            done_reg   <= in_last_reg;
            status_reg <= status_next;
            dlen_reg   <= accum_next;
        end
    end

    assign out_valid      = out_vld_reg;
    assign payload_byte   = pbyte_reg;
    assign payload_valid  = pvalid_reg;
    assign done_res       = done_reg;
    assign status         = status_reg;
    assign decoded_length = dlen_reg;

endmodule
